// ===== rtl/stws_pkg.sv =====
// ----------------------------------------------------------------------------
// stws_pkg
// Types, constants and the segment decoder shared by the stopwatch files.
// ----------------------------------------------------------------------------
package stws_pkg;

   localparam int unsigned DIGITS       = 5;   // digits shown, 1 to 5
   localparam int unsigned DIGIT_FIELDS = 5;   // digit fields in a result word
   localparam int unsigned PERIOD_W     = 17;
   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned CSR_INDEX_W  = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_PERIOD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_PERIOD   = 2'd2;

   // timer limits after reset (period minus one)
   localparam logic [COUNT_W-1:0] SECOND_LIMIT_RESET = 16'(32000 - 1);
   localparam logic [COUNT_W-1:0] HOLD_LIMIT_RESET   = 16'(16000 - 1);
   localparam logic [COUNT_W-1:0] FAST_LIMIT_RESET   = 16'(17 - 1);

   typedef logic [3:0] bcd_digit_type;
   typedef bcd_digit_type [DIGIT_FIELDS-1:0] bcd_type;

   // 65535 in decimal, least significant digit at index 0
   localparam bcd_type BCD_MAX = {4'd6, 4'd5, 4'd5, 4'd3, 4'd5};
   localparam bcd_digit_type BCD_NINE = 4'd9;

   typedef enum logic [2:0] {
      MODE_RUNNING   = 3'd0,
      MODE_PAUSED    = 3'd1,
      MODE_HOLDING   = 3'd2,
      MODE_FAST_UP   = 3'd3,
      MODE_FAST_DOWN = 3'd4
   } mode_type;

   typedef struct packed {
      logic [DIGIT_FIELDS-1:0][7:0] digits;
      logic [COUNT_W-1:0]           count_value;
      logic                         led_on;
      logic                         colon_on;
      logic                         paused_symbol;
   } rsp_word_type;

   localparam logic [7:0] SEG_BLANK = 8'h00;

   function automatic logic [7:0] seg_pattern(input bcd_digit_type d);
      logic [7:0] p;
      case (d)
         4'd0:    p = 8'hFC;
         4'd1:    p = 8'h60;
         4'd2:    p = 8'hDB;
         4'd3:    p = 8'hF1;
         4'd4:    p = 8'h67;
         4'd5:    p = 8'hB7;
         4'd6:    p = 8'hBF;
         4'd7:    p = 8'hE0;
         4'd8:    p = 8'hFF;
         4'd9:    p = 8'hF7;
         default: p = SEG_BLANK;
      endcase
      return p;
   endfunction

   // period register to timer limit: zero acts as one, above 65536 as 65536
   function automatic logic [COUNT_W-1:0] period_limit(input logic [PERIOD_W-1:0] p);
      logic [COUNT_W-1:0] lim;
      if (p[PERIOD_W-1]) begin
         lim = '1;
      end else if (p[COUNT_W-1:0] == '0) begin
         lim = '0;
      end else begin
         lim = p[COUNT_W-1:0] - COUNT_W'(1);
      end
      return lim;
   endfunction

endpackage

// ===== rtl/stws_if.sv =====
// ----------------------------------------------------------------------------
// stws_if
// Valid/ready channels of the stopwatch: button word in, display word out.
// ----------------------------------------------------------------------------
interface stws_req_if;
   logic valid;
   logic ready;
   logic button_one;
   logic button_two;

   modport source (output valid, output button_one, output button_two, input ready);
   modport sink (input valid, input button_one, input button_two, output ready);
endinterface

interface stws_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digit_units;
   logic [7:0] digit_tens;
   logic [7:0] digit_hundreds;
   logic [7:0] digit_thousands;
   logic [7:0] digit_ten_thousands;
   logic [15:0] count_value;
   logic       led_on;
   logic       colon_on;
   logic       paused_symbol;

   modport source (output valid, output digit_units, output digit_tens,
                   output digit_hundreds, output digit_thousands,
                   output digit_ten_thousands, output count_value,
                   output led_on, output colon_on, output paused_symbol,
                   input ready);
   modport sink (input valid, input digit_units, input digit_tens,
                 input digit_hundreds, input digit_thousands,
                 input digit_ten_thousands, input count_value,
                 input led_on, input colon_on, input paused_symbol,
                 output ready);
endinterface

// ===== rtl/stws_obuf.sv =====
// ----------------------------------------------------------------------------
// stws_obuf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module stws_obuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  stws_pkg::rsp_word_type push_word,
   output logic                  push_ready,
   stws_rsp_if.source            rsp_chan
);
   import stws_pkg::*;

   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   logic         pop;
   logic         push;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;
   assign pop        = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      // oldest word always sits in the main register
      if (push) begin
         if (!main_valid_in) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid               = main_valid_ff;
   assign rsp_chan.digit_units         = main_ff.digits[0];
   assign rsp_chan.digit_tens          = main_ff.digits[1];
   assign rsp_chan.digit_hundreds      = main_ff.digits[2];
   assign rsp_chan.digit_thousands     = main_ff.digits[3];
   assign rsp_chan.digit_ten_thousands = main_ff.digits[4];
   assign rsp_chan.count_value         = main_ff.count_value;
   assign rsp_chan.led_on              = main_ff.led_on;
   assign rsp_chan.colon_on            = main_ff.colon_on;
   assign rsp_chan.paused_symbol       = main_ff.paused_symbol;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word held without a main word");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push |=> main_valid_ff)
      else $error("pushed word lost");

   a_main_held: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !rsp_chan.ready |=> main_valid_ff && $stable(main_ff))
      else $error("stalled word changed");

endmodule

// ===== rtl/stopwatch_seven_segment_controller_unit.sv =====
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_controller_unit
// Stopwatch counter with pause, hold-to-clear, fast stepping and display.
// ----------------------------------------------------------------------------
// Each request word is one slow tick with the two button levels; each one
// gives exactly one response word with five segment patterns, the binary
// count and the LED, colon and pause symbols after that tick. A word is
// taken every clock cycle while the buffer has room: the mode, timer and count
// update is combinational, and a decimal copy of the count is stepped alongside
// the binary one, so the display needs no conversion. Responses pass through a
// two-entry buffer, so one response may wait while the next request is taken;
// with the response side stalled, the request side stops after two words.
// Period writes on the csr port take effect on the next tick; a period of
// zero acts as one and a period above 65536 as 65536. No clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module stopwatch_seven_segment_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [stws_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stws_pkg::PERIOD_W-1:0]       csr_wdata,
   stws_req_if.sink                            req_chan,
   stws_rsp_if.source                          rsp_chan
);
   import stws_pkg::*;

   logic [COUNT_W-1:0] second_lim_ff, hold_lim_ff, fast_lim_ff;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   bcd_type            bcd_ff, bcd_in;
   logic               parity_ff, parity_in;
   logic               led_ff, led_in;
   logic               colon_ff, colon_in;
   logic               pause_ff, pause_in;
   logic               last_b1_ff, last_b2_ff;

   logic               req_fire;
   logic               buf_ready;
   logic               b1, b2, e1, e2;
   mode_type           idle_mode;
   logic [COUNT_W-1:0] lim_sel;
   logic               fire;
   logic [COUNT_W-1:0] div_step;
   logic               do_inc, do_dec, do_clr;
   bcd_type            bcd_inc, bcd_dec;
   rsp_word_type       word;

   assign req_chan.ready = buf_ready;
   assign req_fire       = req_chan.valid && buf_ready;
   assign b1             = req_chan.button_one;
   assign b2             = req_chan.button_two;
   assign e1             = b1 && !last_b1_ff;
   assign e2             = b2 && !last_b2_ff;
   assign idle_mode      = (mode_ff == MODE_PAUSED) ? MODE_PAUSED : MODE_RUNNING;

   // period registers are kept as timer limits
   always_ff @(posedge clock) begin
      if (reset) begin
         second_lim_ff <= SECOND_LIMIT_RESET;
         hold_lim_ff   <= HOLD_LIMIT_RESET;
         fast_lim_ff   <= FAST_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SECOND_PERIOD: second_lim_ff <= period_limit(csr_wdata);
            CSR_HOLD_PERIOD:   hold_lim_ff   <= period_limit(csr_wdata);
            CSR_FAST_PERIOD:   fast_lim_ff   <= period_limit(csr_wdata);
            default:           ;
         endcase
      end
   end

   // shared tick timer
   always_comb begin
      case (mode_ff)
         MODE_HOLDING:                 lim_sel = hold_lim_ff;
         MODE_FAST_UP, MODE_FAST_DOWN: lim_sel = fast_lim_ff;
         default:                      lim_sel = second_lim_ff;
      endcase
   end

   assign fire     = div_ff >= lim_sel;
   assign div_step = fire ? '0 : div_ff + COUNT_W'(1);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_HOLDING: begin
            if (!b1) begin
               if (b2) begin
                  mode_in = MODE_FAST_UP;
               end else begin
                  mode_in = parity_ff ? MODE_PAUSED : MODE_RUNNING;
               end
            end
         end
         MODE_FAST_UP: begin
            if (!b2) begin
               mode_in = MODE_RUNNING;
            end else if (b1) begin
               mode_in = MODE_FAST_DOWN;
            end
         end
         MODE_FAST_DOWN: begin
            if (!b1) begin
               mode_in = b2 ? MODE_FAST_UP : MODE_RUNNING;
            end
         end
         default: begin
            if (b2 && (e1 || e2)) begin
               mode_in = MODE_FAST_UP;
            end else if (e1) begin
               mode_in = MODE_HOLDING;
            end else begin
               mode_in = idle_mode;
            end
         end
      endcase
   end

   // timer, count and symbol actions
   always_comb begin
      div_in    = div_ff;
      parity_in = parity_ff;
      pause_in  = pause_ff;
      led_in    = led_ff;
      colon_in  = colon_ff;
      do_inc    = 1'b0;
      do_dec    = 1'b0;
      do_clr    = 1'b0;
      case (mode_ff)
         MODE_HOLDING: begin
            if (b1) begin
               div_in = div_step;
               if (fire) begin
                  do_clr    = 1'b1;
                  parity_in = 1'b1;
                  pause_in  = 1'b1;
               end
            end else begin
               pause_in = parity_ff;
               div_in   = '0;
            end
         end
         MODE_FAST_UP: begin
            if (!b2 || b1) begin
               div_in = '0;
            end else begin
               div_in = div_step;
               do_inc = fire;
            end
         end
         MODE_FAST_DOWN: begin
            if (!b1) begin
               // back to fast up keeps the timer value instead of clearing it
               if (!b2) begin
                  div_in = '0;
               end
            end else begin
               div_in = div_step;
               do_dec = fire;
            end
         end
         default: begin
            if (b2 && (e1 || e2)) begin
               div_in = '0;
            end else if (e1) begin
               parity_in = !parity_ff;
               div_in    = '0;
            end else if (idle_mode == MODE_RUNNING) begin
               div_in = div_step;
               if (fire) begin
                  do_inc   = 1'b1;
                  led_in   = !led_ff;
                  colon_in = !colon_ff;
               end
            end
         end
      endcase
   end

   // decimal copy of the count, stepped with the binary count
   always_comb begin
      logic carry;
      logic borrow;
      carry  = 1'b1;
      borrow = 1'b1;
      for (int i = 0; i < DIGIT_FIELDS; i++) begin
         if (carry) begin
            bcd_inc[i] = (bcd_ff[i] == BCD_NINE) ? '0 : bcd_ff[i] + 4'd1;
         end else begin
            bcd_inc[i] = bcd_ff[i];
         end
         if (borrow) begin
            bcd_dec[i] = (bcd_ff[i] == '0) ? BCD_NINE : bcd_ff[i] - 4'd1;
         end else begin
            bcd_dec[i] = bcd_ff[i];
         end
         carry  = carry && (bcd_ff[i] == BCD_NINE);
         borrow = borrow && (bcd_ff[i] == '0);
      end
   end

   always_comb begin
      count_in = count_ff;
      bcd_in   = bcd_ff;
      if (do_clr) begin
         count_in = '0;
         bcd_in   = '0;
      end else if (do_inc) begin
         count_in = count_ff + COUNT_W'(1);
         bcd_in   = (count_ff == '1) ? bcd_type'('0) : bcd_inc;
      end else if (do_dec) begin
         count_in = count_ff - COUNT_W'(1);
         bcd_in   = (count_ff == '0) ? BCD_MAX : bcd_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RUNNING;
         div_ff     <= '0;
         count_ff   <= '0;
         bcd_ff     <= '0;
         parity_ff  <= 1'b0;
         led_ff     <= 1'b0;
         colon_ff   <= 1'b0;
         pause_ff   <= 1'b0;
         last_b1_ff <= 1'b0;
         last_b2_ff <= 1'b0;
      end else if (req_fire) begin
         mode_ff    <= mode_in;
         div_ff     <= div_in;
         count_ff   <= count_in;
         bcd_ff     <= bcd_in;
         parity_ff  <= parity_in;
         led_ff     <= led_in;
         colon_ff   <= colon_in;
         pause_ff   <= pause_in;
         last_b1_ff <= b1;
         last_b2_ff <= b2;
      end
   end

   // response word from the updated state
   always_comb begin
      for (int i = 0; i < DIGIT_FIELDS; i++) begin
         word.digits[i] = (i < DIGITS) ? seg_pattern(bcd_in[i]) : SEG_BLANK;
      end
      word.count_value   = count_in;
      word.led_on        = led_in;
      word.colon_on      = colon_in;
      word.paused_symbol = pause_in;
   end

   stws_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_word  (word),
      .push_ready (buf_ready),
      .rsp_chan   (rsp_chan)
   );

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff) && $stable(bcd_ff))
      else $error("count moved without a request word");

   a_bcd_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (bcd_ff == '0))
      else $error("decimal count out of step with binary count");

   a_hold_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff == MODE_HOLDING && b1 && fire
      |=> count_ff == '0 && parity_ff && pause_ff)
      else $error("hold did not clear and pause");

endmodule

// ===== bench/stopwatch_seven_segment_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_controller_unit_test
// Self-checking bench for the stopwatch display controller.
// ----------------------------------------------------------------------------
// Button words go in on the request channel, and a model of the stopwatch
// predicts the display word that each one produces. Every response word is
// compared with the oldest prediction, field by field. A directed pass walks
// through pause, resume, hold-to-clear, fast stepping and count wrap. Period
// extremes follow. Random button gestures then run under several period
// settings, with random gaps and stalls on both channels. One stretch holds
// the response side off long enough to stall the request side.
// ----------------------------------------------------------------------------
module stopwatch_seven_segment_controller_unit_test;
   import stws_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 500000;
   localparam logic [PERIOD_W-1:0] PERIOD_TOP = 17'd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [PERIOD_W-1:0]    csr_wdata;

   stws_req_if req_chan ();
   stws_rsp_if rsp_chan ();

   stopwatch_seven_segment_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #1 clock = ~clock;

   // stopwatch state as the block should hold it
   logic [PERIOD_W-1:0] second_period_q, hold_period_q, fast_period_q;
   logic [COUNT_W-1:0]  sw_count, sw_divider;
   mode_type            sw_mode;
   logic                sw_parity, sw_led, sw_colon, sw_pause;
   logic                sw_last_one, sw_last_two;

   logic [7:0] segment_rom [10] = '{8'hFC, 8'h60, 8'hDB, 8'hF1, 8'h67,
                                    8'hB7, 8'hBF, 8'hE0, 8'hFF, 8'hF7};

   rsp_word_type display_expected [$];
   bit           mismatch_seen = 1'b0;
   bit           idle_mode = 1'b1;
   int unsigned  words_sent = 0;
   int unsigned  words_checked = 0;
   int unsigned  cycle_count = 0;
   int unsigned  rx_hold_cycles = 0;

   function automatic void reset_stopwatch();
      second_period_q = 17'd32000;
      hold_period_q   = 17'd16000;
      fast_period_q   = 17'd17;
      sw_count    = '0;
      sw_divider  = '0;
      sw_mode     = MODE_RUNNING;
      sw_parity   = 1'b0;
      sw_led      = 1'b0;
      sw_colon    = 1'b0;
      sw_pause    = 1'b0;
      sw_last_one = 1'b0;
      sw_last_two = 1'b0;
   endfunction

   // advance the divider; report when it wraps at the period
   function automatic bit timer_fires(input logic [PERIOD_W-1:0] period);
      logic [PERIOD_W-1:0] lim;
      if (period == '0) begin
         lim = '0;
      end else if (period > PERIOD_TOP) begin
         lim = PERIOD_TOP - 1'b1;
      end else begin
         lim = period - 1'b1;
      end
      if ({1'b0, sw_divider} >= lim) begin
         sw_divider = '0;
         return 1'b1;
      end
      sw_divider = sw_divider + 1'b1;
      return 1'b0;
   endfunction

   function automatic rsp_word_type stopwatch_tick(input logic b1, input logic b2);
      rsp_word_type       w;
      logic [COUNT_W-1:0] rest;
      bit                 rise_one, rise_two;
      int                 i;
      rise_one = b1 && !sw_last_one;
      rise_two = b2 && !sw_last_two;
      case (sw_mode)
         MODE_HOLDING: begin
            if (b1) begin
               if (timer_fires(hold_period_q)) begin
                  sw_count  = '0;
                  sw_parity = 1'b1;
                  sw_pause  = 1'b1;
               end
            end else begin
               // release decides pause or resume, then fast up may take over
               if (sw_parity) begin
                  sw_mode = MODE_PAUSED;
               end else begin
                  sw_mode = MODE_RUNNING;
               end
               sw_pause   = sw_parity;
               sw_divider = '0;
               if (b2) sw_mode = MODE_FAST_UP;
            end
         end
         MODE_FAST_UP: begin
            if (!b2) begin
               sw_mode    = MODE_RUNNING;
               sw_divider = '0;
            end else if (b1) begin
               sw_mode    = MODE_FAST_DOWN;
               sw_divider = '0;
            end else if (timer_fires(fast_period_q)) begin
               sw_count = sw_count + 1'b1;
            end
         end
         MODE_FAST_DOWN: begin
            if (!b1) begin
               // back to fast up keeps the divider value instead of clearing it
               if (b2) begin
                  sw_mode = MODE_FAST_UP;
               end else begin
                  sw_mode    = MODE_RUNNING;
                  sw_divider = '0;
               end
            end else if (timer_fires(fast_period_q)) begin
               sw_count = sw_count - 1'b1;
            end
         end
         default: begin
            if (sw_mode != MODE_PAUSED) sw_mode = MODE_RUNNING;
            if (b2 && (rise_one || rise_two)) begin
               sw_mode    = MODE_FAST_UP;
               sw_divider = '0;
            end else if (rise_one) begin
               sw_parity  = ~sw_parity;
               sw_mode    = MODE_HOLDING;
               sw_divider = '0;
            end else if (sw_mode == MODE_RUNNING && timer_fires(second_period_q)) begin
               sw_count = sw_count + 1'b1;
               sw_led   = ~sw_led;
               sw_colon = ~sw_colon;
            end
         end
      endcase
      sw_last_one = b1;
      sw_last_two = b2;

      rest = sw_count;
      for (i = 0; i < DIGIT_FIELDS; i++) begin
         if (i < DIGITS) begin
            w.digits[i] = segment_rom[4'(rest % 16'd10)];
            rest = rest / 16'd10;
         end else begin
            w.digits[i] = SEG_BLANK;
         end
      end
      w.count_value   = sw_count;
      w.led_on        = sw_led;
      w.colon_on      = sw_colon;
      w.paused_symbol = sw_pause;
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // track config writes, predict on each accepted word, check each response
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         reset_stopwatch();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SECOND_PERIOD: second_period_q = csr_wdata;
               CSR_HOLD_PERIOD:   hold_period_q   = csr_wdata;
               CSR_FAST_PERIOD:   fast_period_q   = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            display_expected.push_back(stopwatch_tick(req_chan.button_one,
                                                      req_chan.button_two));
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            words_checked++;
            if (display_expected.size() == 0) begin
               $error("response word arrived with none expected");
               mismatch_seen = 1'b1;
            end else begin
               want = display_expected.pop_front();
               check_field("digit_units", 16'(want.digits[0]),
                           16'(rsp_chan.digit_units));
               check_field("digit_tens", 16'(want.digits[1]),
                           16'(rsp_chan.digit_tens));
               check_field("digit_hundreds", 16'(want.digits[2]),
                           16'(rsp_chan.digit_hundreds));
               check_field("digit_thousands", 16'(want.digits[3]),
                           16'(rsp_chan.digit_thousands));
               check_field("digit_ten_thousands", 16'(want.digits[4]),
                           16'(rsp_chan.digit_ten_thousands));
               check_field("count_value", want.count_value, rsp_chan.count_value);
               check_field("led_on", 16'(want.led_on), 16'(rsp_chan.led_on));
               check_field("colon_on", 16'(want.colon_on), 16'(rsp_chan.colon_on));
               check_field("paused_symbol", 16'(want.paused_symbol),
                           16'(rsp_chan.paused_symbol));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response side: random stalls, or one long hold-off when requested
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rx_hold_cycles != 0) begin
            stall = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            stall = idle_mode ? $urandom_range(19, 0) : 0;
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // hold valid across back-to-back words; drop it only during a gap
   task automatic send_tick(input logic b1, input logic b2);
      int unsigned gap;
      gap = idle_mode ? $urandom_range(19, 0) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.button_one <= b1;
      req_chan.button_two <= b2;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_run(input logic b1, input logic b2, input int unsigned n);
      repeat (n) send_tick(b1, b2);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (words_checked < words_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_periods(input logic [PERIOD_W-1:0] second_p,
                                input logic [PERIOD_W-1:0] hold_p,
                                input logic [PERIOD_W-1:0] fast_p);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SECOND_PERIOD;
      csr_wdata <= second_p;
      @(posedge clock);
      csr_index <= CSR_HOLD_PERIOD;
      csr_wdata <= hold_p;
      @(posedge clock);
      csr_index <= CSR_FAST_PERIOD;
      csr_wdata <= fast_p;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed();
      idle_mode = 1'b1;
      // zero fast period acts as one: a step every tick
      write_periods(17'd2, 17'd3, 17'd0);
      send_run(1'b0, 1'b0, 4);
      // short press pauses, next short press resumes
      send_tick(1'b1, 1'b0);
      send_run(1'b0, 1'b0, 2);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      // long hold clears and pauses
      send_run(1'b1, 1'b0, 4);
      send_tick(1'b0, 1'b0);
      // both pressed from pause: fast up, then down through zero and back up
      send_run(1'b1, 1'b1, 3);
      send_run(1'b0, 1'b1, 2);
      send_tick(1'b0, 1'b0);
      // button two pressed during hold: fast up after release of button one
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      // button two alone, then fast down with button two released first
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_run(1'b1, 1'b0, 2);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_period_extremes();
      int unsigned k;
      idle_mode = 1'b1;
      write_periods(PERIOD_TOP, '1, PERIOD_TOP);
      for (k = 0; k < 12; k++) send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      write_periods('0, '0, '0);
      for (k = 0; k < 16; k++) send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      write_periods(17'd1, 17'd1, 17'd1);
      for (k = 0; k < 12; k++) send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
   endtask

   // button gestures a user would make, with some noise mixed in
   task automatic play_gestures(input int unsigned quota);
      int unsigned start, kind, reps;
      start = words_sent;
      while (words_sent - start < quota) begin
         kind = $urandom_range(99, 0);
         if (kind < 25) begin
            send_run(1'b0, 1'b0, $urandom_range(12, 1));
         end else if (kind < 45) begin
            send_run(1'b1, 1'b0, $urandom_range(2, 1));
            send_run(1'b0, 1'b0, $urandom_range(3, 1));
         end else if (kind < 58) begin
            send_run(1'b1, 1'b0, $urandom_range(30, 2));
            send_run(1'b0, 1'b0, $urandom_range(3, 1));
         end else if (kind < 80) begin
            send_run(1'b0, 1'b1, $urandom_range(10, 1));
            reps = $urandom_range(3, 0);
            repeat (reps) begin
               send_run(1'b1, 1'b1, $urandom_range(8, 1));
               send_run(1'b0, 1'b1, $urandom_range(6, 1));
            end
            if ($urandom_range(1, 0)) send_run(1'b1, 1'b1, $urandom_range(4, 1));
            if ($urandom_range(1, 0)) send_run(1'b1, 1'b0, $urandom_range(4, 1));
            send_tick(1'b0, 1'b0);
         end else if (kind < 88) begin
            send_run(1'b1, 1'b0, $urandom_range(6, 1));
            send_run(1'b1, 1'b1, $urandom_range(4, 1));
            send_run(1'b0, 1'b1, $urandom_range(5, 1));
            send_tick(1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(4, 1))
               send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
         end
      end
   endtask

   task automatic test_random_phases();
      int unsigned phase;
      for (phase = 0; phase < 8; phase++) begin
         write_periods(PERIOD_W'($urandom_range(8, 0)),
                       PERIOD_W'($urandom_range(12, 0)),
                       PERIOD_W'($urandom_range(4, 0)));
         // every third phase runs without gaps or stalls
         idle_mode = (phase % 3) != 2;
         play_gestures(120);
      end
   endtask

   task automatic test_backpressure();
      write_periods(17'd3, 17'd5, 17'd2);
      idle_mode = 1'b0;
      rx_hold_cycles = 300;
      play_gestures(40);
      idle_mode = 1'b1;
   endtask

   initial begin
      csr_we              <= 1'b0;
      csr_index           <= CSR_SECOND_PERIOD;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.button_one <= 1'b0;
      req_chan.button_two <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_period_extremes();
      test_random_phases();
      test_backpressure();

      wait_idle();
      repeat (16) @(posedge clock);
      if (display_expected.size() != 0) begin
         $error("%0d expected response words never arrived", display_expected.size());
         mismatch_seen = 1'b1;
      end
      if (!mismatch_seen) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
